// ----- design/clt_pkg.sv -----
`timescale 1ns / 1ps

package clt_pkg;

   // most fields a line may ever hold, caps the programmed limit
   localparam int LINE_FIELD_CAP = 128;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_PLAIN  = 2'd1;
   localparam logic [1:0] MODE_QUOTED = 2'd2;
   localparam logic [1:0] MODE_QSEEN  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [1:0] STATUS_OPEN_QT  = 2'd2;
   localparam logic [1:0] STATUS_COUNT    = 2'd3;

   localparam logic [1:0] CSR_FIELD_LIMIT     = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_FIELDS = 2'd1;
   localparam logic [1:0] CSR_CHECK_COUNT     = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   localparam logic [7:0] FIELD_LIMIT_RESET     = 8'd100;
   localparam logic [7:0] EXPECTED_FIELDS_RESET = 8'd0;
   localparam logic       CHECK_COUNT_RESET     = 1'b0;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic [6:0] field_index;
      logic       field_closed;
      logic [7:0] fields_done;
      logic       line_done;
      logic [1:0] line_status;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] field_limit;
      logic [7:0] expected_fields;
      logic       check_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0] parse_mode;
      logic [7:0] field_counter;
      logic [1:0] line_error;
      logic       error_seen;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      parse_mode:    MODE_START,
      field_counter: 8'd0,
      line_error:    STATUS_OK,
      error_seen:    1'b0
   };

endpackage

// ----- design/clt_csr.sv -----
`timescale 1ns / 1ps

module clt_csr
   import clt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIELD_LIMIT:     cfg_in.field_limit     = csr_data;
            CSR_EXPECTED_FIELDS: cfg_in.expected_fields = csr_data;
            CSR_CHECK_COUNT:     cfg_in.check_count     = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_limit     <= FIELD_LIMIT_RESET;
         cfg_ff.expected_fields <= EXPECTED_FIELDS_RESET;
         cfg_ff.check_count     <= CHECK_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/clt_parse.sv -----
`timescale 1ns / 1ps

module clt_parse
   import clt_pkg::*;
(
   input  cfg_type         cfg,
   input  line_state_type  cur,
   input  req_payload_type req,
   output line_state_type  nxt,
   output rsp_payload_type rsp
);

   logic [7:0] limit_used;
   logic       at_start;
   logic [7:0] b;

   assign b = req.data_byte;
   assign limit_used = (cfg.field_limit > 8'(LINE_FIELD_CAP)) ? 8'(LINE_FIELD_CAP)
                                                             : cfg.field_limit;

   always_comb begin
      nxt      = cur;
      rsp      = '0;
      at_start = 1'b0;
      if (req.operation == OP_BYTE) begin
         if (!cur.error_seen) begin
            unique case (cur.parse_mode)
               MODE_QSEEN: begin
                  if (b == CH_QUOTE) begin
                     // doubled quote gives one quote
                     rsp.out_valid   = 1'b1;
                     rsp.out_byte    = b;
                     rsp.field_index = cur.field_counter[6:0];
                     nxt.parse_mode  = MODE_QUOTED;
                  end else begin
                     nxt.field_counter = cur.field_counter + 8'd1;
                     rsp.field_closed  = 1'b1;
                     nxt.parse_mode    = MODE_START;
                     at_start          = (b != CH_COMMA);
                  end
               end
               MODE_START: at_start = 1'b1;
               MODE_PLAIN: begin
                  if (b == CH_COMMA) begin
                     nxt.field_counter = cur.field_counter + 8'd1;
                     rsp.field_closed  = 1'b1;
                     nxt.parse_mode    = MODE_START;
                  end else begin
                     rsp.out_valid   = 1'b1;
                     rsp.out_byte    = b;
                     rsp.field_index = cur.field_counter[6:0];
                  end
               end
               MODE_QUOTED: begin
                  if (b == CH_QUOTE) begin
                     nxt.parse_mode = MODE_QSEEN;
                  end else begin
                     rsp.out_valid   = 1'b1;
                     rsp.out_byte    = b;
                     rsp.field_index = cur.field_counter[6:0];
                  end
               end
               default: ;
            endcase

            // a byte that opens a new field
            if (at_start) begin
               priority if (nxt.field_counter >= limit_used) begin
                  nxt.error_seen = 1'b1;
                  nxt.line_error = STATUS_TOO_MANY;
               end else if (b == CH_QUOTE) begin
                  nxt.parse_mode = MODE_QUOTED;
               end else if (b == CH_COMMA) begin
                  nxt.field_counter = nxt.field_counter + 8'd1;
                  rsp.field_closed  = 1'b1;
               end else begin
                  nxt.parse_mode  = MODE_PLAIN;
                  rsp.out_valid   = 1'b1;
                  rsp.out_byte    = b;
                  rsp.field_index = nxt.field_counter[6:0];
               end
            end
         end
         rsp.fields_done = nxt.field_counter;
      end else begin
         if (!cur.error_seen) begin
            if (cur.parse_mode == MODE_QUOTED) begin
               nxt.error_seen = 1'b1;
               nxt.line_error = STATUS_OPEN_QT;
            end else if (cur.parse_mode == MODE_PLAIN || cur.parse_mode == MODE_QSEEN) begin
               nxt.field_counter = cur.field_counter + 8'd1;
               rsp.field_closed  = 1'b1;
            end
            if (!nxt.error_seen && cfg.check_count
                && nxt.field_counter != cfg.expected_fields) begin
               nxt.error_seen = 1'b1;
               nxt.line_error = STATUS_COUNT;
            end
         end
         rsp.line_done   = 1'b1;
         rsp.line_status = nxt.line_error;
         rsp.fields_done = nxt.field_counter;
         nxt             = LINE_CLEAR;
      end
   end

endmodule

// ----- design/csv_line_tokenizer.sv -----
`timescale 1ns / 1ps

// CSV line tokenizer: takes one line byte or end-of-line mark per request and
// returns exactly one response per request, in order. Throughput is one request
// per clock cycle while responses are taken; an accepted request is held in the
// input register, parsed there, and its response is registered in the output
// register, from which it can be taken. The rate is set by the per-byte parse state
// (mode, field count, sticky error), which is read and updated combinationally
// between the input register and the response register. While a finished
// response waits, the input register takes one more request and then the input
// stalls until the response is taken. The csr registers are field_limit
// (index 0), expected_fields (index 1) and check_count (index 2); write them
// only while no request is in flight.
module csv_line_tokenizer
   import clt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_data
);

   cfg_type         cfg;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_data_ff;
   line_state_type  line_ff;
   line_state_type  line_in;
   rsp_payload_type rsp_calc;
   logic            advance;
   logic            req_fire;
   logic            rsp_fire;

   clt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   clt_parse u_parse (
      .cfg (cfg),
      .cur (line_ff),
      .req (in_data_ff),
      .nxt (line_in),
      .rsp (rsp_calc)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_valid_ff && rsp_ready;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_fire ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         line_ff      <= LINE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            line_ff <= line_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= rsp_calc;
      end
   end

endmodule

// ----- bench/tb_csv_line_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_csv_line_tokenizer;
   import clt_pkg::*;

   // index 3 maps to no register and must be ignored
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         HOLD_CYCLES = 120;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [7:0]      csr_data = '0;

   csv_line_tokenizer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_payload_type line_items[$];
   rsp_payload_type tokens_due[$];

   // register copies used for prediction
   logic [7:0] field_cap   = FIELD_LIMIT_RESET;
   logic [7:0] want_fields = EXPECTED_FIELDS_RESET;
   logic       count_check = CHECK_COUNT_RESET;

   // line state as the tokenizer should hold it
   logic [1:0] parse_state   = MODE_START;
   logic [7:0] closed_fields = 8'd0;
   logic [1:0] line_fault    = STATUS_OK;
   logic       fault_held    = 1'b0;

   logic        req_fire = 1'b0;
   logic        quiet = 1'b0;
   int          hold_asks = 0;
   int          holds_started = 0;
   int          hold_left = 0;
   int          errors = 0;
   int          items_queued = 0;
   int          responses_checked = 0;
   int          csr_settings = 0;
   int          status_count[4] = '{0, 0, 0, 0};
   int unsigned cycles = 0;

   function automatic rsp_payload_type tokenize_item(input req_payload_type r);
      rsp_payload_type o;
      logic            begin_field;
      logic [7:0]      cap;
      o = '0;
      begin_field = 1'b0;
      cap = (field_cap > LINE_FIELD_CAP) ? 8'(LINE_FIELD_CAP) : field_cap;
      if (r.operation == OP_BYTE) begin
         if (!fault_held) begin
            case (parse_state)
               MODE_QSEEN: begin
                  if (r.data_byte == CH_QUOTE) begin
                     // doubled quote stands for one quote
                     o.out_valid = 1'b1;
                     o.out_byte = r.data_byte;
                     o.field_index = closed_fields[6:0];
                     parse_state = MODE_QUOTED;
                  end else begin
                     closed_fields++;
                     o.field_closed = 1'b1;
                     parse_state = MODE_START;
                     begin_field = (r.data_byte != CH_COMMA);
                  end
               end
               MODE_START: begin_field = 1'b1;
               MODE_PLAIN: begin
                  if (r.data_byte == CH_COMMA) begin
                     closed_fields++;
                     o.field_closed = 1'b1;
                     parse_state = MODE_START;
                  end else begin
                     o.out_valid = 1'b1;
                     o.out_byte = r.data_byte;
                     o.field_index = closed_fields[6:0];
                  end
               end
               default: begin
                  if (r.data_byte == CH_QUOTE) begin
                     parse_state = MODE_QSEEN;
                  end else begin
                     o.out_valid = 1'b1;
                     o.out_byte = r.data_byte;
                     o.field_index = closed_fields[6:0];
                  end
               end
            endcase
            if (begin_field) begin
               if (closed_fields >= cap) begin
                  fault_held = 1'b1;
                  line_fault = STATUS_TOO_MANY;
               end else if (r.data_byte == CH_QUOTE) begin
                  parse_state = MODE_QUOTED;
               end else if (r.data_byte == CH_COMMA) begin
                  closed_fields++;
                  o.field_closed = 1'b1;
               end else begin
                  parse_state = MODE_PLAIN;
                  o.out_valid = 1'b1;
                  o.out_byte = r.data_byte;
                  o.field_index = closed_fields[6:0];
               end
            end
         end
         o.fields_done = closed_fields;
      end else begin
         if (!fault_held) begin
            if (parse_state == MODE_QUOTED) begin
               fault_held = 1'b1;
               line_fault = STATUS_OPEN_QT;
            end else if (parse_state == MODE_PLAIN || parse_state == MODE_QSEEN) begin
               closed_fields++;
               o.field_closed = 1'b1;
            end
            if (!fault_held && count_check && closed_fields != want_fields) begin
               fault_held = 1'b1;
               line_fault = STATUS_COUNT;
            end
         end
         o.line_done = 1'b1;
         o.line_status = line_fault;
         o.fields_done = closed_fields;
         parse_state = MODE_START;
         closed_fields = 8'd0;
         line_fault = STATUS_OK;
         fault_held = 1'b0;
      end
      return o;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (line_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
            req_payload <= line_items.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off each time one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_asks != holds_started) begin
         holds_started <= holds_started + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 30);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      req_fire <= req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tokens_due.size() == 0) begin
            $display("%0t: response with no request waiting, expected none, actual %h",
                     $time, rsp_payload);
            errors++;
         end else begin
            want = tokens_due.pop_front();
            check_field("out_byte", want.out_byte, rsp_payload.out_byte);
            check_field("out_valid", want.out_valid, rsp_payload.out_valid);
            check_field("field_index", want.field_index, rsp_payload.field_index);
            check_field("field_closed", want.field_closed, rsp_payload.field_closed);
            check_field("fields_done", want.fields_done, rsp_payload.fields_done);
            check_field("line_done", want.line_done, rsp_payload.line_done);
            check_field("line_status", want.line_status, rsp_payload.line_status);
            responses_checked++;
            if (want.line_done) status_count[want.line_status]++;
         end
      end
      if (!reset && req_valid && req_ready) tokens_due.push_back(tokenize_item(req_payload));
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, tokens_due.size());
         $display("csv_line_tokenizer test failed");
         $finish;
      end
   end

   task automatic put(input logic op, input logic [7:0] b);
      req_payload_type r;
      r.operation = op;
      r.data_byte = b;
      line_items.push_back(r);
      items_queued++;
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_COMMA);
      return b;
   endfunction

   task automatic make_line(input int most_fields);
      int nf;
      int len;
      nf = $urandom_range(0, most_fields);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) put(OP_BYTE, CH_COMMA);
         len = $urandom_range(0, 4);
         case ($urandom_range(0, 2))
            0: ;
            1: repeat (len + 1) put(OP_BYTE, text_byte());
            default: begin
               put(OP_BYTE, CH_QUOTE);
               repeat (len) begin
                  case ($urandom_range(0, 3))
                     0: begin
                        put(OP_BYTE, CH_QUOTE);
                        put(OP_BYTE, CH_QUOTE);
                     end
                     1: put(OP_BYTE, CH_COMMA);
                     default: put(OP_BYTE, text_byte());
                  endcase
               end
               put(OP_BYTE, CH_QUOTE);
            end
         endcase
      end
      if (nf > 0 && $urandom_range(0, 4) == 0) put(OP_BYTE, CH_COMMA);
      put(OP_EOL, 8'($urandom_range(0, 255)));
   endtask

   // random quotes and commas, often malformed
   task automatic make_noise_line();
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 3))
            0: put(OP_BYTE, CH_QUOTE);
            1: put(OP_BYTE, CH_COMMA);
            default: put(OP_BYTE, 8'($urandom_range(0, 255)));
         endcase
      end
      put(OP_EOL, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_lines(input int n_items, input int most_fields);
      int first;
      first = items_queued;
      while (items_queued - first < n_items) begin
         if ($urandom_range(0, 4) == 0) make_noise_line();
         else make_line(most_fields);
      end
   endtask

   task automatic drain();
      while (line_items.size() != 0 || req_valid || tokens_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FIELD_LIMIT:     field_cap = val;
         CSR_EXPECTED_FIELDS: want_fields = val;
         CSR_CHECK_COUNT:     count_check = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] lim, input logic [7:0] fields,
                             input logic chk);
      csr_write(CSR_FIELD_LIMIT, lim);
      csr_write(CSR_EXPECTED_FIELDS, fields);
      csr_write(CSR_CHECK_COUNT, {7'($urandom), chk});
      csr_settings++;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: plain, quoted, leading and trailing commas, open quote
      put(OP_BYTE, 8'h61); put(OP_BYTE, CH_COMMA); put(OP_BYTE, 8'h62); put(OP_EOL, 8'h00);
      put(OP_BYTE, CH_QUOTE); put(OP_BYTE, 8'h78); put(OP_BYTE, CH_QUOTE);
      put(OP_BYTE, CH_QUOTE); put(OP_BYTE, CH_QUOTE); put(OP_EOL, 8'h5A);
      put(OP_BYTE, CH_COMMA); put(OP_BYTE, 8'h63); put(OP_EOL, 8'h00);
      put(OP_BYTE, 8'h64); put(OP_BYTE, CH_COMMA); put(OP_EOL, 8'h00);
      // text right after a closing quote opens another field
      put(OP_BYTE, CH_QUOTE); put(OP_BYTE, CH_QUOTE); put(OP_BYTE, 8'h7A); put(OP_EOL, 8'h00);
      put(OP_BYTE, CH_QUOTE); put(OP_BYTE, 8'h71); put(OP_EOL, 8'h00);
      put(OP_BYTE, 8'h00); put(OP_BYTE, 8'hFF); put(OP_EOL, 8'hFF);
      drain();

      set_config(8'd3, 8'd2, 1'b1);
      csr_write(CSR_UNUSED, 8'hFF);
      run_lines(50, 5);
      drain();

      // zero limit: no field may begin
      set_config(8'd0, 8'd0, 1'b0);
      run_lines(20, 3);
      drain();

      // limit above the cap, full-width lines
      set_config(8'd255, 8'd128, 1'b1);
      repeat (130) put(OP_BYTE, CH_COMMA);
      put(OP_EOL, 8'h00);
      repeat (127) put(OP_BYTE, CH_COMMA);
      put(OP_BYTE, 8'h41);
      put(OP_EOL, 8'h00);
      drain();

      // back-to-back stretch while the receiver holds off
      set_config(8'd128, 8'd0, 1'b0);
      quiet = 1'b1;
      hold_asks++;
      run_lines(60, 6);
      drain();
      quiet = 1'b0;

      set_config(8'd1, 8'd1, 1'b1);
      run_lines(30, 4);
      drain();

      repeat (3) begin
         set_config(8'($urandom_range(1, 8)), 8'($urandom_range(0, 6)),
                    1'($urandom_range(0, 1)));
         run_lines(25, 6);
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d requests over %0d register settings, %0d responses checked",
               items_queued, csr_settings, responses_checked);
      $display("line ends: %0d ok, %0d too many fields, %0d open quote, %0d count mismatch",
               status_count[0], status_count[1], status_count[2], status_count[3]);
      if (errors == 0) begin
         $display("csv_line_tokenizer test passed");
      end else begin
         $display("csv_line_tokenizer test failed");
      end
      $finish;
   end

endmodule
